// ===== rtl/rdfb_pkg.sv =====
// Shared types, constants and pixel packing functions for the RGB565 framebuffer.
// Used by rdfb_clear_seq and rgb565_dithered_framebuffer_unit.
package rdfb_pkg;

  typedef enum logic [2:0] {
    REQ_WR_COLOR  = 3'd0,
    REQ_WR_RAW    = 3'd1,
    REQ_READ      = 3'd2,
    REQ_CLR_COLOR = 3'd3,
    REQ_CLR_RAW   = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_DITHER_ENABLE = 2'd2
  } cfg_reg_t;

  localparam int unsigned WIDTH_RESET  = 512;
  localparam int unsigned HEIGHT_RESET = 256;

  // 8x8 ordered dither offsets, indexed by {y[2:0], x[2:0]}
  localparam logic [2:0] RB_OFS [64] = '{
    3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7,
    3'd4, 3'd2, 3'd5, 3'd4, 3'd4, 3'd3, 3'd6, 3'd4,
    3'd1, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd7,
    3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd4, 3'd5, 3'd3,
    3'd1, 3'd6, 3'd2, 3'd7, 3'd1, 3'd6, 3'd2, 3'd7,
    3'd4, 3'd3, 3'd6, 3'd4, 3'd4, 3'd2, 3'd6, 3'd4,
    3'd2, 3'd7, 3'd1, 3'd7, 3'd2, 3'd7, 3'd1, 3'd6,
    3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd3, 3'd5, 3'd3
  };

  localparam logic [2:0] G_OFS [64] = '{
    3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
    3'd2, 3'd1, 3'd3, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2,
    3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
    3'd2, 3'd1, 3'd3, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2,
    3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3, 3'd1, 3'd3,
    3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  // Fill color and mode handed to the clear sequencer at the start of a clear
  typedef struct packed {
    logic        start;
    logic        raw_mode;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] raw_pixel;
  } clr_ctrl_t;

  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [2:0] d);
    logic [8:0] s;
    s = {1'b0, c} + {6'd0, d};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [15:0] swap_bytes(input logic [15:0] w);
    return {w[7:0], w[15:8]};
  endfunction

  // Pack an RGB888 color to byte-swapped 565, with optional ordered dither
  function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [2:0] xl,
                                          input logic [2:0] yl, input logic dith);
    logic [5:0] idx;
    logic [7:0] rr;
    logic [7:0] gg;
    logic [7:0] bb;
    idx = {yl, xl};
    rr  = dith ? sat_add(r, RB_OFS[idx]) : r;
    gg  = dith ? sat_add(g, G_OFS[idx]) : g;
    bb  = dith ? sat_add(b, RB_OFS[idx]) : b;
    return swap_bytes({rr[7:3], gg[7:2], bb[7:3]});
  endfunction

endpackage

// ===== rtl/rgb565_dithered_framebuffer_unit.sv =====
// RGB565 framebuffer with ordered dithering: top level, request pipeline and config.
// Depends on rdfb_pkg, rdfb_frame_mem and rdfb_clear_seq.
// Stages: capture, range check and address multiply, memory access, result register.
// Throughput: one item per cycle for writes and reads while the output is not stalled;
// a clear holds the input while it sweeps the frame, one pixel per cycle.
// Reset: sync active-high; clears pipeline valids, registers to 512x256, no dither.
module rgb565_dithered_framebuffer_unit #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // x[15:0], y[31:16], red[39:32], green[47:40],
                                      // blue[55:48], raw_pixel[71:56]
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16],
                                      // raw_out[39:24]
  output logic        m_axis_tuser,   // ok[0]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import rdfb_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);

  // ---------------------------------------------------------------------------
  // Configuration registers; always ready. Effective size clamps to 1..MAX.
  // ---------------------------------------------------------------------------
  logic [9:0]    image_width;
  logic [8:0]    image_height;
  logic          dither_enable;
  logic [WW-1:0] eff_width;
  logic [HW-1:0] eff_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 10'(WIDTH_RESET);
      image_height  <= 9'(HEIGHT_RESET);
      dither_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data[8:0];
        CFG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      eff_width = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_height = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_height = HW'(MAX_HEIGHT);
    end else begin
      eff_height = HW'(image_height);
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. All stages move together on en; a clear sweep freezes
  // them so items behind the clear see the filled frame.
  // ---------------------------------------------------------------------------
  logic clr_busy;
  logic en;
  logic out_valid;

  assign en            = (!out_valid || m_axis_tready) && !clr_busy;
  assign s_axis_tready = en;

  // stage 1: captured request
  logic        v1;
  logic [2:0]  s1_req;
  logic [15:0] s1_x;
  logic [15:0] s1_y;
  logic [7:0]  s1_red;
  logic [7:0]  s1_green;
  logic [7:0]  s1_blue;
  logic [15:0] s1_raw;

  // stage 2: range check done, row offset multiplied
  logic          v2;
  logic [2:0]    s2_req;
  logic          s2_inside;
  logic [XW-1:0] s2_x;
  logic [2:0]    s2_yl;
  logic [AW-1:0] s2_row;
  logic [7:0]    s2_red;
  logic [7:0]    s2_green;
  logic [7:0]    s2_blue;
  logic [15:0]   s2_raw;

  // stage 3: memory accessed, read data arrives
  logic       v3;
  logic [2:0] s3_req;
  logic       s3_inside;

  logic inside1;
  assign inside1 = !s1_x[15] && !s1_y[15] &&
                   (32'(s1_x) < 32'(eff_width)) && (32'(s1_y) < 32'(eff_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_req   <= s_axis_tuser;
      s1_x     <= s_axis_tdata[15:0];
      s1_y     <= s_axis_tdata[31:16];
      s1_red   <= s_axis_tdata[39:32];
      s1_green <= s_axis_tdata[47:40];
      s1_blue  <= s_axis_tdata[55:48];
      s1_raw   <= s_axis_tdata[71:56];

      s2_req    <= s1_req;
      s2_inside <= inside1;
      s2_x      <= s1_x[XW-1:0];
      s2_yl     <= s1_y[2:0];
      s2_row    <= AW'(s1_y[YW-1:0]) * AW'(eff_width);
      s2_red    <= s1_red;
      s2_green  <= s1_green;
      s2_blue   <= s1_blue;
      s2_raw    <= s1_raw;

      s3_req    <= s2_req;
      s3_inside <= s2_inside;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame memory access from stage 2, or from the clear sequencer while busy
  // ---------------------------------------------------------------------------
  logic          s2_is_clear;
  logic          pipe_we;
  logic          pipe_re;
  logic [AW-1:0] pipe_addr;
  logic [15:0]   pipe_wdata;
  logic [AW-1:0] clr_addr;
  logic [15:0]   clr_wdata;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;
  clr_ctrl_t     clr_ctrl;

  assign s2_is_clear = (s2_req == REQ_CLR_COLOR) || (s2_req == REQ_CLR_RAW);
  assign pipe_we     = en && v2 && s2_inside &&
                       ((s2_req == REQ_WR_COLOR) || (s2_req == REQ_WR_RAW));
  assign pipe_re     = en && v2 && s2_inside && (s2_req == REQ_READ);
  assign pipe_addr   = AW'(s2_x) + s2_row;
  assign pipe_wdata  = (s2_req == REQ_WR_RAW) ? s2_raw
                     : pack565(s2_red, s2_green, s2_blue, s2_x[2:0], s2_yl,
                               dither_enable);

  // hand the fill color to the sequencer as the clear leaves stage 2
  assign clr_ctrl.start     = en && v2 && s2_is_clear;
  assign clr_ctrl.raw_mode  = s2_req == REQ_CLR_RAW;
  assign clr_ctrl.red       = s2_red;
  assign clr_ctrl.green     = s2_green;
  assign clr_ctrl.blue      = s2_blue;
  assign clr_ctrl.raw_pixel = s2_raw;

  rdfb_clear_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WW         (WW),
    .HW         (HW),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW)
  ) u_clear_seq (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (clr_ctrl),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .dith       (dither_enable),
    .busy       (clr_busy),
    .wr_addr    (clr_addr),
    .wr_data    (clr_wdata)
  );

  assign ram_we    = clr_busy || pipe_we;
  assign ram_re    = pipe_re;
  assign ram_addr  = clr_busy ? clr_addr : pipe_addr;
  assign ram_wdata = clr_busy ? clr_wdata : pipe_wdata;

  rdfb_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register. Read data holds in the memory while the pipeline stalls.
  // ---------------------------------------------------------------------------
  logic        s3_read_hit;
  logic [15:0] s3_word;
  logic        res_ok;
  logic        out_ok;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [15:0] out_raw;

  assign s3_read_hit = s3_inside && (s3_req == REQ_READ);
  assign s3_word     = swap_bytes(ram_rdata);

  always_comb begin
    case (s3_req)
      REQ_WR_COLOR, REQ_WR_RAW, REQ_READ: res_ok = s3_inside;
      REQ_CLR_COLOR, REQ_CLR_RAW:         res_ok = 1'b1;
      default:                            res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end else if (m_axis_tready) begin
      // drop a result taken while a clear sweep holds the pipeline
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ok <= res_ok;
      if (s3_read_hit) begin
        // widen 5/6/5 channels by replicating the top bits
        out_red   <= {s3_word[15:11], s3_word[15:13]};
        out_green <= {s3_word[10:5], s3_word[10:9]};
        out_blue  <= {s3_word[4:0], s3_word[4:2]};
        out_raw   <= ram_rdata;
      end else begin
        out_red   <= '0;
        out_green <= '0;
        out_blue  <= '0;
        out_raw   <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_ok;
  assign m_axis_tdata  = {out_raw, out_blue, out_green, out_red};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_axis_tready)
    else $error("input accepted during clear sweep");

  a_no_read_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !pipe_re && !pipe_we)
    else $error("pipeline memory access during clear sweep");

  a_clear_start_idle: assert property (@(posedge clk) disable iff (rst)
    clr_ctrl.start |=> clr_busy && !s_axis_tready)
    else $error("clear start did not enter sweep");

  a_reject_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> (m_axis_tdata == '0))
    else $error("rejected result carries nonzero data");

endmodule

// ===== rtl/rdfb_frame_mem.sv =====
// Single-port synchronous frame memory with a registered read.
// No dependencies.
module rdfb_frame_mem #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [15:0]   wdata,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/rdfb_clear_seq.sv =====
// Clear sequencer: sweeps the active frame one pixel per cycle and produces writes.
// Depends on rdfb_pkg for the control struct and pixel packing.
module rdfb_clear_seq #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned WW = $clog2(MAX_WIDTH + 1),
  parameter int unsigned HW = $clog2(MAX_HEIGHT + 1),
  parameter int unsigned XW = $clog2(MAX_WIDTH),
  parameter int unsigned YW = $clog2(MAX_HEIGHT),
  parameter int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic               clk,
  input  logic               rst,
  input  rdfb_pkg::clr_ctrl_t ctrl,
  input  logic [WW-1:0]      eff_width,
  input  logic [HW-1:0]      eff_height,
  input  logic               dith,
  output logic               busy,
  output logic [AW-1:0]      wr_addr,
  output logic [15:0]        wr_data
);
  import rdfb_pkg::*;

  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [AW-1:0] clear_position;
  clr_ctrl_t     fill;
  logic          row_end;
  logic          last_row;

  assign row_end  = 32'(cx) == 32'(eff_width) - 32'd1;
  assign last_row = 32'(cy) == 32'(eff_height) - 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      cx             <= '0;
      cy             <= '0;
      clear_position <= '0;
    end else if (busy) begin
      // advance raster position, drop busy after the last pixel
      clear_position <= clear_position + AW'(1);
      if (row_end) begin
        cx <= '0;
        if (last_row) begin
          busy           <= 1'b0;
          cy             <= '0;
          clear_position <= '0;
        end else begin
          cy <= cy + YW'(1);
        end
      end else begin
        cx <= cx + XW'(1);
      end
    end else if (ctrl.start) begin
      busy           <= 1'b1;
      cx             <= '0;
      cy             <= '0;
      clear_position <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && ctrl.start) begin
      fill <= ctrl;
    end
  end

  assign wr_addr = clear_position;
  assign wr_data = fill.raw_mode ? fill.raw_pixel
                 : pack565(fill.red, fill.green, fill.blue, cx[2:0], cy[2:0], dith);

endmodule
